// ----- sv/npcs_pkg.sv -----
// Package for the nearest palette colour search block: shared types, codes,
// default sizes and the sRGB-to-linear table builder. No dependencies.
package npcs_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int PALETTE_ENTRIES_DEF = 256;
   localparam int PALETTE_COUNT_DEF   = 2;
   localparam int LINEAR_BITS_DEF     = 16;

   // Widest linear component the table builder supports
   localparam int LINEAR_BITS_MAX = 24;

   // One cell per colour component: red, green, blue
   localparam int COMPONENTS = 3;

   // Action codes carried by req_action
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REJECT
   } state_type;

   // Control that travels with each candidate along the cell chain
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } flow_type;

   // sRGB byte to linear fraction, widest form; users keep the low bits
   typedef logic [255:0][LINEAR_BITS_MAX-1:0] lin_rom_type;

   // Q62 product with round to nearest: floor((a*b + 2^61) / 2^62)
   function automatic logic [127:0] qmul(input logic [127:0] a, input logic [127:0] b);
      logic [127:0] prod;
      prod = a * b;
      return (prod + (128'd1 << 61)) >> 62;
   endfunction

   // r^5 in Q62, built from rounded products
   function automatic logic [127:0] pow5(input logic [127:0] r);
      logic [127:0] r2;
      r2 = qmul(r, r);
      return qmul(qmul(r2, r2), r);
   endfunction

   // Builds the sRGB-to-linear table at elaboration for a given fraction width
   function automatic lin_rom_type build_lin_rom(input int bits);
      lin_rom_type  rom;
      logic [127:0] lin_max;
      logic [127:0] n;
      logic [127:0] t;
      logic [127:0] s;
      logic [127:0] lo;
      logic [127:0] hi;
      logic [127:0] mid;
      logic [127:0] lin;
      lin_max = (128'd1 << bits) - 128'd1;
      for (int c = 0; c < 256; c++) begin
         if (c <= 10) begin
            // linear segment of the curve
            lin = (128'd100 * 128'(c) * lin_max + 128'd164730) / 128'd329460;
         end else begin
            // power segment: square, then fifth root by bisection
            n  = 128'd1000 * 128'(c) + 128'd14025;
            t  = (n << 62) / 128'd269025;
            s  = qmul(t, t);
            lo = '0;
            hi = 128'd1 << 62;
            for (int k = 0; k < 64; k++) begin
               if (lo < hi) begin
                  mid = lo + ((hi - lo + 128'd1) >> 1);
                  if (pow5(mid) <= s) begin
                     lo = mid;
                  end else begin
                     hi = mid - 128'd1;
                  end
               end
            end
            lin = qmul(qmul(s, lo), lin_max);
         end
         rom[c] = lin[LINEAR_BITS_MAX-1:0];
      end
      return rom;
   endfunction

endpackage

// ----- sv/npcs_cell.sv -----
// One component cell of the distance chain: holds that component of every
// palette entry and adds its squared difference to the passing sum. Uses npcs_pkg.
module npcs_cell #(
   parameter  int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF,
   parameter  int PALETTE_COUNT   = npcs_pkg::PALETTE_COUNT_DEF,
   parameter  int LINEAR_BITS     = npcs_pkg::LINEAR_BITS_DEF,
   localparam int Depth           = PALETTE_ENTRIES * PALETTE_COUNT,
   localparam int AddrW           = $clog2(Depth),
   localparam int IdxW            = $clog2(PALETTE_ENTRIES),
   localparam int SqW             = 2 * LINEAR_BITS,
   localparam int DistW           = 2 * LINEAR_BITS + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   // palette write and query capture share the converted value
   input  logic                      wr_en,
   input  logic [AddrW-1:0]          wr_addr,
   input  logic                      query_load,
   input  logic [LINEAR_BITS-1:0]    lin_value,
   // from the left neighbour
   input  npcs_pkg::flow_type        flow_i,
   input  logic [AddrW-1:0]          addr_i,
   input  logic [IdxW-1:0]           idx_i,
   input  logic [DistW-1:0]          dist_i,
   // to the right neighbour
   output npcs_pkg::flow_type        flow_o,
   output logic [AddrW-1:0]          addr_o,
   output logic [IdxW-1:0]           idx_o,
   output logic [DistW-1:0]          dist_o
);

   // this component of every palette entry
   logic [LINEAR_BITS-1:0] mem_ff [Depth];
   logic [LINEAR_BITS-1:0] query_ff;

   // stage registers
   npcs_pkg::flow_type     flow1_ff, flow2_ff, flow3_ff, flow4_ff;
   logic [AddrW-1:0]       addr1_ff, addr2_ff, addr3_ff, addr4_ff;
   logic [IdxW-1:0]        idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [DistW-1:0]       dist1_ff, dist2_ff, dist3_ff, dist4_ff;
   logic [LINEAR_BITS-1:0] rd_ff;
   logic [LINEAR_BITS-1:0] diff_ff;
   logic [SqW-1:0]         sq_ff;

   // palette write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= lin_value;
      end
      rd_ff <= mem_ff[addr_i];
   end

   // query component, held for the whole scan
   always_ff @(posedge clock) begin
      if (query_load) begin
         query_ff <= lin_value;
      end
   end

   // control through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         flow1_ff <= '0;
         flow2_ff <= '0;
         flow3_ff <= '0;
         flow4_ff <= '0;
      end else begin
         flow1_ff <= flow_i;
         flow2_ff <= flow1_ff;
         flow3_ff <= flow2_ff;
         flow4_ff <= flow3_ff;
      end
   end

   // payload: read, absolute difference, square, accumulate
   always_ff @(posedge clock) begin
      addr1_ff <= addr_i;
      idx1_ff  <= idx_i;
      dist1_ff <= dist_i;

      diff_ff  <= (rd_ff > query_ff) ? (rd_ff - query_ff) : (query_ff - rd_ff);
      addr2_ff <= addr1_ff;
      idx2_ff  <= idx1_ff;
      dist2_ff <= dist1_ff;

      sq_ff    <= SqW'(diff_ff) * SqW'(diff_ff);
      addr3_ff <= addr2_ff;
      idx3_ff  <= idx2_ff;
      dist3_ff <= dist2_ff;

      dist4_ff <= dist3_ff + DistW'(sq_ff);
      addr4_ff <= addr3_ff;
      idx4_ff  <= idx3_ff;
   end

   assign flow_o = flow4_ff;
   assign addr_o = addr4_ff;
   assign idx_o  = idx4_ff;
   assign dist_o = dist4_ff;

endmodule

// ----- sv/npcs_best.sv -----
// End of the chain: keeps the least distance of a scan, lowest index on ties,
// and registers the result word. Uses npcs_pkg.
module npcs_best #(
   parameter  int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF,
   parameter  int LINEAR_BITS     = npcs_pkg::LINEAR_BITS_DEF,
   localparam int IdxW            = $clog2(PALETTE_ENTRIES),
   localparam int DistW           = 2 * LINEAR_BITS + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  npcs_pkg::flow_type flow_i,
   input  logic [IdxW-1:0]    idx_i,
   input  logic [DistW-1:0]   dist_i,
   output logic               res_valid,
   output logic [7:0]         res_index,
   output logic               res_exact
);

   logic [DistW-1:0] best_dist_ff;
   logic [IdxW-1:0]  best_idx_ff;
   logic             res_valid_ff;
   logic [7:0]       res_index_ff;
   logic             res_exact_ff;

   logic             take;
   logic [DistW-1:0] win_dist;
   logic [IdxW-1:0]  win_idx;

   // strict compare keeps the earlier index on a tie
   always_comb begin
      take     = flow_i.first || (dist_i < best_dist_ff);
      win_dist = take ? dist_i : best_dist_ff;
      win_idx  = take ? idx_i : best_idx_ff;
   end

   // running best
   always_ff @(posedge clock) begin
      if (flow_i.valid) begin
         best_dist_ff <= win_dist;
         best_idx_ff  <= win_idx;
      end
   end

   // result word on the last candidate
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= flow_i.valid && flow_i.last;
      end
   end

   always_ff @(posedge clock) begin
      if (flow_i.valid && flow_i.last) begin
         res_index_ff <= 8'(win_idx);
         res_exact_ff <= (win_dist == '0);
      end
   end

   assign res_valid = res_valid_ff;
   assign res_index = res_index_ff;
   assign res_exact = res_exact_ff;

endmodule

// ----- sv/nearest_palette_color_search_top.sv -----
// Top level of the nearest palette colour search block: sequencer, sRGB table
// and a chain of three component cells ending in the best tracker.
// Depends on npcs_pkg, npcs_cell and npcs_best.
//
// Use: one command channel (start, busy, req_*) and one result channel
// (rsp_strobe, rsp_*). A word is taken at a rising edge with start high and
// busy low. req_action selects a load (writes one entry of the chosen palette,
// gives no result) or a query (searches the chosen palette).
// A load leaves busy low, so loads may follow every cycle.
// A query raises busy and scans one entry per cycle through the chain: its
// result word is on the rsp_ ports for one cycle, and busy falls after the
// edge that takes it, so a new query is taken only once the last has given
// its result. The scan is paced by the single read port of each cell memory.
// A query to a palette beyond PALETTE_COUNT answers index 0, no exact match,
// in the cycle after it is taken.
// Reset clears the sequencer and the chain; palette contents are not cleared
// and an entry must be loaded before a query reads it.
// The receiver cannot hold results off: each result word is shown once.
module nearest_palette_color_search_top #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF,
   parameter int PALETTE_COUNT   = npcs_pkg::PALETTE_COUNT_DEF,
   parameter int LINEAR_BITS     = npcs_pkg::LINEAR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_action,
   input  logic       req_palette_select,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_strobe,
   output logic [7:0] rsp_nearest_index,
   output logic       rsp_exact_match
);

   localparam int Depth = PALETTE_ENTRIES * PALETTE_COUNT;
   localparam int AddrW = $clog2(Depth);
   localparam int IdxW  = $clog2(PALETTE_ENTRIES);
   localparam int DistW = 2 * LINEAR_BITS + 2;
   localparam int Cells = npcs_pkg::COMPONENTS;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_ENTRIES - 1);
   localparam npcs_pkg::lin_rom_type LinRom = npcs_pkg::build_lin_rom(LINEAR_BITS);

   npcs_pkg::state_type state_ff, state_in;
   logic [IdxW-1:0]     cnt_ff, cnt_in;
   logic                sel_ff;

   logic                accept;
   logic                sel_ok;
   logic                idx_ok;
   logic                wr_en;
   logic                query_load;
   logic [AddrW-1:0]    wr_addr;
   logic [AddrW-1:0]    scan_addr;
   npcs_pkg::flow_type  issue_flow;

   logic [LINEAR_BITS-1:0] lin_value [Cells];

   npcs_pkg::flow_type  chain_flow [Cells+1];
   logic [AddrW-1:0]    chain_addr [Cells+1];
   logic [IdxW-1:0]     chain_idx  [Cells+1];
   logic [DistW-1:0]    chain_dist [Cells+1];

   logic                res_valid;
   logic [7:0]          res_index;
   logic                res_exact;

   // command decode
   assign accept  = start && !busy;
   assign sel_ok  = int'(req_palette_select) < PALETTE_COUNT;
   assign idx_ok  = int'(req_entry_index) < PALETTE_ENTRIES;
   assign wr_addr = AddrW'(int'(req_palette_select) * PALETTE_ENTRIES + int'(req_entry_index));
   assign scan_addr = AddrW'(int'(sel_ff) * PALETTE_ENTRIES + int'(cnt_ff));

   // sRGB bytes to linear fractions
   assign lin_value[0] = LinRom[req_red][LINEAR_BITS-1:0];
   assign lin_value[1] = LinRom[req_green][LINEAR_BITS-1:0];
   assign lin_value[2] = LinRom[req_blue][LINEAR_BITS-1:0];

   // sequencer next state and scan counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         npcs_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_action == npcs_pkg::ACTION_QUERY) begin
               state_in = sel_ok ? npcs_pkg::ST_SCAN : npcs_pkg::ST_REJECT;
            end
         end
         npcs_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastIdx) begin
               state_in = npcs_pkg::ST_DRAIN;
            end
         end
         npcs_pkg::ST_DRAIN: begin
            if (res_valid) begin
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         npcs_pkg::ST_REJECT: begin
            state_in = npcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = npcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npcs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // palette captured at query start
   always_ff @(posedge clock) begin
      if (query_load) begin
         sel_ff <= req_palette_select;
      end
   end

   // sequencer outputs
   always_comb begin
      busy             = (state_ff != npcs_pkg::ST_IDLE);
      wr_en            = accept && req_action == npcs_pkg::ACTION_LOAD && sel_ok && idx_ok;
      query_load       = accept && req_action == npcs_pkg::ACTION_QUERY;
      issue_flow.valid = (state_ff == npcs_pkg::ST_SCAN);
      issue_flow.first = (cnt_ff == '0);
      issue_flow.last  = (cnt_ff == LastIdx);
      if (state_ff == npcs_pkg::ST_REJECT) begin
         rsp_strobe        = 1'b1;
         rsp_nearest_index = '0;
         rsp_exact_match   = 1'b0;
      end else begin
         rsp_strobe        = res_valid;
         rsp_nearest_index = res_index;
         rsp_exact_match   = res_exact;
      end
   end

   // head of the chain
   assign chain_flow[0] = issue_flow;
   assign chain_addr[0] = scan_addr;
   assign chain_idx[0]  = cnt_ff;
   assign chain_dist[0] = '0;

   // one cell per colour component
   for (genvar k = 0; k < Cells; k++) begin : g_cell
      npcs_cell #(
         .PALETTE_ENTRIES (PALETTE_ENTRIES),
         .PALETTE_COUNT   (PALETTE_COUNT),
         .LINEAR_BITS     (LINEAR_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_en),
         .wr_addr    (wr_addr),
         .query_load (query_load),
         .lin_value  (lin_value[k]),
         .flow_i     (chain_flow[k]),
         .addr_i     (chain_addr[k]),
         .idx_i      (chain_idx[k]),
         .dist_i     (chain_dist[k]),
         .flow_o     (chain_flow[k+1]),
         .addr_o     (chain_addr[k+1]),
         .idx_o      (chain_idx[k+1]),
         .dist_o     (chain_dist[k+1])
      );
   end

   // least distance of the scan
   npcs_best #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .LINEAR_BITS     (LINEAR_BITS)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .flow_i    (chain_flow[Cells]),
      .idx_i     (chain_idx[Cells]),
      .dist_i    (chain_dist[Cells]),
      .res_valid (res_valid),
      .res_index (res_index),
      .res_exact (res_exact)
   );

endmodule

// ----- sv/npcs_checker.sv -----
// Port-level checks for the nearest palette colour search block, bound to
// the top level. Uses npcs_pkg for the action codes.
module npcs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_strobe
);

   // a load word leaves the block free for the next word
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == npcs_pkg::ACTION_LOAD) |=> !busy)
      else $error("busy raised after a load word");

   // a query word makes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == npcs_pkg::ACTION_QUERY) |=> busy)
      else $error("busy not raised after a query word");

   // results only come from a query in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word while idle");

   // one result word per query, then the block is free
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result word repeated or block still busy");

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_action (req_action),
   .rsp_strobe (rsp_strobe)
);

// ----- sim/nearest_palette_color_search_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for nearest_palette_color_search_top: fills both palettes, then runs
// directed and random loads and queries against a linear-light palette mirror.
// Depends on npcs_pkg and the RTL of the block.
module nearest_palette_color_search_top_test;

   localparam int     ENTRIES       = npcs_pkg::PALETTE_ENTRIES_DEF;
   localparam int     PALETTES      = npcs_pkg::PALETTE_COUNT_DEF;
   localparam int     LIN_W         = npcs_pkg::LINEAR_BITS_DEF;
   localparam int     RANDOM_WORDS  = 1000;
   localparam int     CALM_TAIL     = 150;
   localparam int     SETTLE_CYCLES = ENTRIES + 20;
   localparam longint CYCLE_LIMIT   = 2000000;

   typedef struct packed {
      logic [7:0] nearest;
      logic       exact;
   } colour_match_type;

   // Mirror of both palettes in linear light, plus the answers still owed
   class palette_mirror;
      logic [LIN_W-1:0] linear_of_byte [256];
      logic [LIN_W-1:0] colour_store [PALETTES][ENTRIES][3];
      colour_match_type awaited [$];
      int errors;
      int loads;
      int queries;
      int exact_answers;

      function new();
         for (int c = 0; c < 256; c++) begin
            linear_of_byte[c] = byte_to_linear(c);
         end
         errors        = 0;
         loads         = 0;
         queries       = 0;
         exact_answers = 0;
      endfunction

      // Q62 product, rounded to nearest
      function logic [127:0] q62_product(logic [127:0] a, logic [127:0] b);
         return (a * b + (128'd1 << 61)) >> 62;
      endfunction

      // sRGB byte to linear fraction of full scale
      function logic [LIN_W-1:0] byte_to_linear(int c);
         logic [127:0] full;
         logic [127:0] num;
         logic [127:0] t;
         logic [127:0] s;
         logic [127:0] lo;
         logic [127:0] hi;
         logic [127:0] mid;
         logic [127:0] sq;
         logic [127:0] lin;
         full = (128'd1 << LIN_W) - 128'd1;
         if (c <= 10) begin
            lin = (128'd100 * 128'(c) * full + 128'd164730) / 128'd329460;
         end else begin
            // square of the scaled value, then its fifth root by bisection
            num = 128'd1000 * 128'(c) + 128'd14025;
            t   = (num << 62) / 128'd269025;
            s   = q62_product(t, t);
            lo  = '0;
            hi  = 128'd1 << 62;
            while (lo < hi) begin
               mid = lo + ((hi - lo + 128'd1) >> 1);
               sq  = q62_product(mid, mid);
               if (q62_product(q62_product(sq, sq), mid) <= s) begin
                  lo = mid;
               end else begin
                  hi = mid - 128'd1;
               end
            end
            lin = q62_product(q62_product(s, lo), full);
         end
         return lin[LIN_W-1:0];
      endfunction

      // Notes an accepted command word; a query queues its expected answer
      function void take_command(logic act, logic sel, logic [7:0] idx,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b);
         logic [LIN_W-1:0] lin [3];
         longint unsigned  best_dist;
         longint unsigned  total;
         longint unsigned  d;
         int               best;
         colour_match_type answer;
         lin[0] = linear_of_byte[r];
         lin[1] = linear_of_byte[g];
         lin[2] = linear_of_byte[b];
         if (act == npcs_pkg::ACTION_LOAD) begin
            loads++;
            for (int k = 0; k < 3; k++) begin
               colour_store[sel][idx][k] = lin[k];
            end
         end else begin
            queries++;
            best      = 0;
            best_dist = 0;
            // strict less-than keeps the lowest index on ties
            for (int i = 0; i < ENTRIES; i++) begin
               total = 0;
               for (int k = 0; k < 3; k++) begin
                  d = (lin[k] > colour_store[sel][i][k]) ? lin[k] - colour_store[sel][i][k]
                                                         : colour_store[sel][i][k] - lin[k];
                  total += d * d;
               end
               if (i == 0 || total < best_dist) begin
                  best      = i;
                  best_dist = total;
               end
            end
            answer.nearest = best[7:0];
            answer.exact   = (best_dist == 0);
            awaited.push_back(answer);
         end
      endfunction

      // Checks one result word against the oldest owed answer
      function void check_match(logic [7:0] nearest, logic exact);
         colour_match_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected answer: index %0d, exact %0b", $time, nearest, exact);
         end else begin
            want = awaited.pop_front();
            if (exact === 1'b1) exact_answers++;
            if (nearest !== want.nearest) begin
               errors++;
               $display("%0t: nearest_index expected %0d, actual %0d",
                        $time, want.nearest, nearest);
            end
            if (exact !== want.exact) begin
               errors++;
               $display("%0t: exact_match expected %0b, actual %0b", $time, want.exact, exact);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       start              = 1'b0;
   logic       busy;
   logic       req_action         = npcs_pkg::ACTION_LOAD;
   logic       req_palette_select = 1'b0;
   logic [7:0] req_entry_index    = '0;
   logic [7:0] req_red            = '0;
   logic [7:0] req_green          = '0;
   logic [7:0] req_blue           = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_nearest_index;
   logic       rsp_exact_match;

   palette_mirror book;
   logic [23:0]   shade_of [PALETTES][ENTRIES];
   bit            idle_on = 1'b0;
   longint        cycle_count = 0;

   nearest_palette_color_search_top dut (.*);

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: run stopped at the cycle limit", $time);
      $display("nearest_palette_color_search_top: mismatch");
      $finish;
   end

   // Result words cannot be held off: check each one as it shows
   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.check_match(rsp_nearest_index, rsp_exact_match);
   end

   // Presents one word at a falling edge and holds it until taken
   task automatic send_word(input logic act, input logic sel, input logic [7:0] idx,
                            input logic [23:0] rgb);
      start              <= 1'b1;
      req_action         <= act;
      req_palette_select <= sel;
      req_entry_index    <= idx;
      req_red            <= rgb[23:16];
      req_green          <= rgb[15:8];
      req_blue           <= rgb[7:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      book.take_command(act, sel, idx, rgb[23:16], rgb[15:8], rgb[7:0]);
      @(negedge clock);
   endtask

   task automatic load_entry(input logic sel, input logic [7:0] idx, input logic [23:0] rgb);
      shade_of[sel][idx] = rgb;
      send_word(npcs_pkg::ACTION_LOAD, sel, idx, rgb);
   endtask

   // entry_index is ignored by queries, so it carries noise
   task automatic query_colour(input logic sel, input logic [23:0] rgb);
      send_word(npcs_pkg::ACTION_QUERY, sel, 8'($urandom), rgb);
   endtask

   // Sometimes drops start for a random gap while idle_on is set
   task automatic pause_sender();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   // Holds off until every owed answer has come
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (book.pending() != 0) @(negedge clock);
   endtask

   // Bytes weighted towards the ends and the linear segment of the curve
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(0, 10));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] random_colour();
      return {random_byte(), random_byte(), random_byte()};
   endfunction

   // Flips the low bit of one component: near, but rarely exact
   function automatic logic [23:0] nudge(input logic [23:0] rgb);
      return rgb ^ (24'd1 << (8 * $urandom_range(0, 2)));
   endfunction

   initial begin
      int          pick;
      logic        sel;
      logic [7:0]  idx;
      logic [23:0] rgb;
      book = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // every entry is written before any query reads it
      for (int i = 0; i < ENTRIES; i++) begin
         pause_sender();
         load_entry(1'b0, 8'(i), random_colour());
      end
      for (int i = 0; i < ENTRIES; i++) begin
         pause_sender();
         load_entry(1'b1, 8'(i), 24'h808080);
      end

      // directed: ties, ends of the index range, extremes of the colour bytes
      query_colour(1'b1, 24'h808080);     // whole palette ties
      query_colour(1'b1, 24'h000000);
      load_entry(1'b1, 8'd255, 24'hFFFFFF);
      query_colour(1'b1, 24'hFFFFFF);     // last entry, exact
      load_entry(1'b1, 8'd0, 24'h000000);
      query_colour(1'b1, 24'h010000);     // close to black, not exact
      query_colour(1'b1, 24'h808080);     // tie now begins at entry 1
      load_entry(1'b1, 8'd77, 24'hFF0000);
      load_entry(1'b1, 8'd78, 24'hFF0000);
      query_colour(1'b1, 24'hFA0000);     // duplicate pair, lower wins
      load_entry(1'b1, 8'd128, 24'h00FF00);
      load_entry(1'b1, 8'd129, 24'h0000FF);
      query_colour(1'b1, 24'h00FF00);
      query_colour(1'b1, 24'h0000FF);
      query_colour(1'b1, 24'h0A0A0A);     // top of the linear segment
      query_colour(1'b1, 24'h0B0B0B);     // bottom of the power segment
      query_colour(1'b0, 24'hFFFFFF);
      query_colour(1'b0, 24'h000000);
      query_colour(1'b0, shade_of[0][255]);
      query_colour(1'b0, shade_of[0][0]);
      drain();

      // random: loads reshape the palettes, queries mostly aim at stored colours
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            idle_on = (n < RANDOM_WORDS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
         end
         if (n == RANDOM_WORDS / 2) drain();
         pause_sender();
         pick = $urandom_range(0, 99);
         sel  = 1'($urandom);
         idx  = 8'($urandom);
         if (pick < 55) begin
            rgb = ($urandom_range(0, 3) == 0) ? shade_of[sel][8'($urandom)] : random_colour();
            load_entry(sel, idx, rgb);
         end else begin
            rgb = shade_of[sel][idx];
            if (pick >= 90) begin
               rgb = random_colour();
            end else if (pick >= 80) begin
               rgb = nudge(rgb);
            end
            query_colour(sel, rgb);
         end
      end

      // wind down
      start <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d palette loads and %0d colour queries over %0d palettes.",
               book.loads, book.queries, PALETTES);
      $display("%0d answers hit a colour exactly; the rest were nearest matches.",
               book.exact_answers);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("nearest_palette_color_search_top: match");
      end else begin
         $display("nearest_palette_color_search_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/npcs_pkg.sv
sv/npcs_cell.sv
sv/npcs_best.sv
sv/nearest_palette_color_search_top.sv
sv/npcs_checker.sv
sim/nearest_palette_color_search_top_test.sv
